// File: hw/rtl/fbpa_pkg.sv
// ----------------------------------------------------------------------------
// fbpa_pkg
// Shared types and codes of the fixed-size block pool allocator: request and
// response words, command and status codes, register indexes.
// ----------------------------------------------------------------------------
`default_nettype none

package fbpa_pkg;

	// Width of byte addresses carried on the ports
	localparam int ADDR_W = 32;
	localparam int REQ_BYTES_W = 17;
	localparam int COUNT_W = 9;
	localparam int CFG_DATA_W = 32;
	localparam int CFG_INDEX_W = 2;
	localparam int TOTAL_W = 9;
	localparam int LOG2_W = 5;

	// Block size limits (log2 of bytes)
	localparam logic [LOG2_W-1:0] LOG2_MIN = 5'd3;
	localparam logic [LOG2_W-1:0] LOG2_MAX = 5'd16;

	// Commands
	localparam logic [1:0] CMD_ALLOC = 2'd0;
	localparam logic [1:0] CMD_FREE = 2'd1;
	localparam logic [1:0] CMD_REBUILD = 2'd2;

	// Response status
	localparam logic [1:0] STAT_OK = 2'd0;
	localparam logic [1:0] STAT_EMPTY = 2'd1;
	localparam logic [1:0] STAT_OUTSIDE = 2'd2;
	localparam logic [1:0] STAT_TOO_LARGE = 2'd3;

	// Configuration register indexes
	localparam logic [CFG_INDEX_W-1:0] REG_POOL_BASE = 2'd0;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_TOTAL = 2'd1;
	localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LOG2 = 2'd2;

	typedef struct packed {
		logic [1:0] cmd;
		logic [REQ_BYTES_W-1:0] request_bytes;
		logic [ADDR_W-1:0] free_addr;
	} req_t;

	typedef struct packed {
		logic [1:0] status;
		logic [ADDR_W-1:0] granted_addr;
		logic [COUNT_W-1:0] allocated_count;
	} rsp_t;

	// Result of the address mapping unit
	typedef struct packed {
		logic [ADDR_W-1:0] grant_addr;
		logic too_large;
		logic free_ok;
		logic [ADDR_W-1:0] free_idx;
		logic [ADDR_W-1:0] last_idx;
	} map_t;

endpackage

`default_nettype wire

// File: hw/rtl/fbpa_ram.sv
// ----------------------------------------------------------------------------
// fbpa_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_ram #(
	parameter int WIDTH = 9,
	parameter int DEPTH = 256
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]              rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: hw/rtl/fbpa_addr_map.sv
// ----------------------------------------------------------------------------
// fbpa_addr_map
// Maps between block indexes and byte addresses: grant address of the head
// block, range check and block index of a returned address, size check.
// ----------------------------------------------------------------------------
`default_nettype none

module fbpa_addr_map #(
	parameter int MAX_BLOCKS = 256
) (
	input  wire logic [fbpa_pkg::ADDR_W-1:0]      pool_base,
	input  wire logic [fbpa_pkg::TOTAL_W-1:0]     block_total,
	input  wire logic [fbpa_pkg::LOG2_W-1:0]      block_size_log2,
	input  wire logic [fbpa_pkg::ADDR_W-1:0]      head_idx,
	input  wire logic [fbpa_pkg::REQ_BYTES_W-1:0] request_bytes,
	input  wire logic [fbpa_pkg::ADDR_W-1:0]      free_addr,
	output fbpa_pkg::map_t                        map
);

	localparam int AW = fbpa_pkg::ADDR_W;

	logic [fbpa_pkg::LOG2_W-1:0] lg;
	logic [AW-1:0] total;
	logic [AW-1:0] total_raw;
	logic [AW-1:0] diff;
	logic [AW-1:0] idx;

	// Clamp the block size and the block count to their legal ranges
	always_comb begin
		if (block_size_log2 < fbpa_pkg::LOG2_MIN) begin
			lg = fbpa_pkg::LOG2_MIN;
		end else if (block_size_log2 > fbpa_pkg::LOG2_MAX) begin
			lg = fbpa_pkg::LOG2_MAX;
		end else begin
			lg = block_size_log2;
		end
	end

	assign total_raw = AW'(block_total);

	always_comb begin
		if (total_raw == '0) begin
			total = AW'(1);
		end else if (total_raw > AW'(MAX_BLOCKS)) begin
			total = AW'(MAX_BLOCKS);
		end else begin
			total = total_raw;
		end
	end

	// Offset into the pool and the block that holds it
	assign diff = free_addr - pool_base;
	assign idx = diff >> lg;

	assign map.grant_addr = pool_base + (head_idx << lg);
	assign map.too_large = AW'(request_bytes) > (AW'(1) << lg);
	assign map.free_ok = (free_addr >= pool_base) && (idx < total);
	assign map.free_idx = idx;
	assign map.last_idx = total - AW'(1);

endmodule

`default_nettype wire

// File: hw/rtl/fixed_block_pool_allocator.sv
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator
// Equal-size block pool with a LIFO free list held in a link memory.
// ----------------------------------------------------------------------------
// Each allocate or free first reads the link of the head block from the link
// RAM, then updates head, count and RAM and loads the response register; this
// update waits while an earlier response is still held. A rebuild answers in
// the same steps and then relinks the list at one block per cycle, over the
// clamped block count, before the next word is taken. After reset a relink
// sweep over all MAX_BLOCKS entries runs while requests stall; configuration
// writes are taken at any time. A finished response waits in its output
// register while the next request is already read.
`default_nettype none

module fixed_block_pool_allocator #(
	parameter int MAX_BLOCKS = 256
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               req_valid,
	output logic                                    req_stall,
	input  wire fbpa_pkg::req_t                     req,
	output logic                                    rsp_valid,
	input  wire logic                               rsp_stall,
	output fbpa_pkg::rsp_t                          rsp,
	input  wire logic                               cfg_we,
	input  wire logic [fbpa_pkg::CFG_INDEX_W-1:0]   cfg_index,
	input  wire logic [fbpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

	localparam int IDX_W = $clog2(MAX_BLOCKS);
	localparam int LINK_W = $clog2(MAX_BLOCKS + 1);
	localparam int AW = fbpa_pkg::ADDR_W;
	localparam logic [LINK_W-1:0] LINK_END = LINK_W'(MAX_BLOCKS);

	localparam logic [1:0] ST_SWEEP = 2'd0;
	localparam logic [1:0] ST_IDLE = 2'd1;
	localparam logic [1:0] ST_EXEC = 2'd2;

	logic [1:0] state_q;
	logic [IDX_W-1:0] sweep_q;
	logic [IDX_W-1:0] sweep_end_q;
	logic [LINK_W-1:0] head_q;
	logic [LINK_W-1:0] count_q;
	fbpa_pkg::req_t req_q;
	logic rsp_valid_q;
	fbpa_pkg::rsp_t rsp_q;

	logic [AW-1:0] pool_base_q;
	logic [fbpa_pkg::TOTAL_W-1:0] block_total_q;
	logic [fbpa_pkg::LOG2_W-1:0] block_log2_q;

	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	logic [LINK_W-1:0] ram_wdata;
	logic [LINK_W-1:0] ram_rdata;

	fbpa_pkg::map_t map;

	logic req_fire;
	logic exec_fire;
	logic [LINK_W-1:0] head_d;
	logic [LINK_W-1:0] count_d;
	fbpa_pkg::rsp_t rsp_d;
	logic rebuild;
	logic free_wr;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pool_base_q <= '0;
			block_total_q <= fbpa_pkg::TOTAL_W'(256);
			block_log2_q <= fbpa_pkg::LOG2_W'(5);
		end else if (cfg_we) begin
			case (cfg_index)
				fbpa_pkg::REG_POOL_BASE: pool_base_q <= cfg_data[AW-1:0];
				fbpa_pkg::REG_BLOCK_TOTAL: block_total_q <= cfg_data[fbpa_pkg::TOTAL_W-1:0];
				fbpa_pkg::REG_BLOCK_LOG2: block_log2_q <= cfg_data[fbpa_pkg::LOG2_W-1:0];
				default: ;
			endcase
		end
	end

	// Link memory: one link per block, end of list is MAX_BLOCKS
	fbpa_ram #(
		.WIDTH(LINK_W),
		.DEPTH(MAX_BLOCKS)
	) u_link_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(head_q[IDX_W-1:0]),
		.rdata(ram_rdata)
	);

	fbpa_addr_map #(
		.MAX_BLOCKS(MAX_BLOCKS)
	) u_addr_map (
		.pool_base(pool_base_q),
		.block_total(block_total_q),
		.block_size_log2(block_log2_q),
		.head_idx(AW'(head_q[IDX_W-1:0])),
		.request_bytes(req_q.request_bytes),
		.free_addr(req_q.free_addr),
		.map(map)
	);

	assign req_stall = (state_q != ST_IDLE);
	assign req_fire = req_valid && !req_stall;
	assign exec_fire = (state_q == ST_EXEC) && (!rsp_valid_q || !rsp_stall);

	// Execute one command against head, count and link memory
	always_comb begin
		head_d = head_q;
		count_d = count_q;
		rebuild = 1'b0;
		free_wr = 1'b0;
		rsp_d.status = fbpa_pkg::STAT_OK;
		rsp_d.granted_addr = '0;
		case (req_q.cmd)
			fbpa_pkg::CMD_ALLOC: begin
				if (map.too_large) begin
					rsp_d.status = fbpa_pkg::STAT_TOO_LARGE;
				end else if (head_q == LINK_END) begin
					rsp_d.status = fbpa_pkg::STAT_EMPTY;
				end else begin
					rsp_d.granted_addr = map.grant_addr;
					head_d = ram_rdata;
					if (count_q != LINK_END) begin
						count_d = count_q + LINK_W'(1);
					end
				end
			end
			fbpa_pkg::CMD_FREE: begin
				if (!map.free_ok) begin
					rsp_d.status = fbpa_pkg::STAT_OUTSIDE;
				end else begin
					free_wr = 1'b1;
					head_d = LINK_W'(map.free_idx[IDX_W-1:0]);
					if (count_q != '0) begin
						count_d = count_q - LINK_W'(1);
					end
				end
			end
			fbpa_pkg::CMD_REBUILD: begin
				rebuild = 1'b1;
				head_d = '0;
				count_d = '0;
			end
			default: ;
		endcase
		rsp_d.allocated_count = fbpa_pkg::COUNT_W'(count_d);
	end

	// Link memory write: relink sweep or push of a freed block
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = (sweep_q == sweep_end_q) ? LINK_END : LINK_W'(sweep_q) + LINK_W'(1);
		if (state_q == ST_SWEEP) begin
			ram_we = 1'b1;
		end else if (exec_fire && free_wr) begin
			ram_we = 1'b1;
			ram_waddr = map.free_idx[IDX_W-1:0];
			ram_wdata = head_q;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			sweep_q <= '0;
			sweep_end_q <= IDX_W'(MAX_BLOCKS - 1);
			head_q <= '0;
			count_q <= '0;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					if (sweep_q == sweep_end_q) begin
						sweep_q <= '0;
						state_q <= ST_IDLE;
					end else begin
						sweep_q <= sweep_q + IDX_W'(1);
					end
				end
				ST_IDLE: begin
					if (req_fire) begin
						state_q <= ST_EXEC;
					end
				end
				ST_EXEC: begin
					if (exec_fire) begin
						head_q <= head_d;
						count_q <= count_d;
						if (rebuild) begin
							sweep_q <= '0;
							sweep_end_q <= map.last_idx[IDX_W-1:0];
							state_q <= ST_SWEEP;
						end else begin
							state_q <= ST_IDLE;
						end
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Capture the request word
	always_ff @(posedge clk) begin
		if (req_fire) begin
			req_q <= req;
		end
	end

	// Response register: hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (exec_fire) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (exec_fire) begin
			rsp_q <= rsp_d;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp = rsp_q;

	// Head and count never pass the end-of-list mark
	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LINK_END)
		else $error("free list head out of range");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= LINK_END)
		else $error("allocated count out of range");

	// A new response appears only from the execute step
	a_rsp_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q == ST_EXEC))
		else $error("response without execute step");

	// An accepted word always moves on to execution
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		req_fire |=> state_q == ST_EXEC)
		else $error("accepted word not executed");

endmodule

`default_nettype wire

// File: sim/fixed_block_pool_allocator_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_test
// Self-checking bench for the block pool allocator. A shadow pool (link table,
// head, count, registers) predicts the reply of every request word when the
// word is queued. A driver offers the words in bursts with gaps, a monitor
// compares each reply field by field, and the reply side stalls on its own
// pattern, with one long hold-off that backs the block up.
// ----------------------------------------------------------------------------

module fixed_block_pool_allocator_test;

	localparam int POOL_BLOCKS = 256;
	localparam int SETTLE_CYCLES = 300;
	localparam int IDLE_LIMIT = 4000;
	localparam int HOLD_CYCLES = 200;
	localparam int WORDS_PER_PHASE = 135;
	localparam int SATURATE_ALLOCS = 260;

	// Command code with no operation behind it
	localparam logic [1:0] CMD_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_stall;
	fbpa_pkg::req_t req = '0;
	logic rsp_valid;
	logic rsp_stall = 1'b0;
	fbpa_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic [fbpa_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
	logic [fbpa_pkg::CFG_DATA_W-1:0] cfg_data = '0;

	// Shadow pool state and register copies
	logic [8:0] link_mem [POOL_BLOCKS];
	logic [8:0] head_blk;
	logic [8:0] used_blocks;
	logic [31:0] base_reg;
	logic [8:0] total_reg;
	logic [4:0] shift_reg;

	fbpa_pkg::req_t words_to_send_q [$];
	fbpa_pkg::rsp_t replies_due_q [$];
	logic [31:0] owned_addr_q [$];

	int error_count = 0;
	int words_taken = 0;
	int idle_cycles = 0;

	fixed_block_pool_allocator #(
		.MAX_BLOCKS(POOL_BLOCKS)
	) dut (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req(req),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Block count and shift as the hardware uses them (clamped)
	function automatic int total_now();
		if (total_reg == 0) return 1;
		if (total_reg > POOL_BLOCKS) return POOL_BLOCKS;
		return int'(total_reg);
	endfunction

	function automatic int shift_now();
		if (shift_reg < fbpa_pkg::LOG2_MIN) return int'(fbpa_pkg::LOG2_MIN);
		if (shift_reg > fbpa_pkg::LOG2_MAX) return int'(fbpa_pkg::LOG2_MAX);
		return int'(shift_reg);
	endfunction

	task automatic reset_pool();
		for (int i = 0; i < POOL_BLOCKS; i++) link_mem[i] = 9'(i + 1);
		head_blk = '0;
		used_blocks = '0;
		base_reg = '0;
		total_reg = 9'd256;
		shift_reg = 5'd5;
	endtask

	// Advance the shadow pool by one request word and return its reply
	function automatic fbpa_pkg::rsp_t predict_reply(input fbpa_pkg::req_t w);
		fbpa_pkg::rsp_t r;
		int lg;
		int total;
		logic [31:0] idx;
		lg = shift_now();
		total = total_now();
		r = '0;
		r.status = fbpa_pkg::STAT_OK;
		case (w.cmd)
		fbpa_pkg::CMD_ALLOC: begin
			if (32'(w.request_bytes) > (32'd1 << lg)) begin
				r.status = fbpa_pkg::STAT_TOO_LARGE;
			end else if (head_blk >= POOL_BLOCKS) begin
				r.status = fbpa_pkg::STAT_EMPTY;
			end else begin
				r.granted_addr = base_reg + (32'(head_blk) << lg);
				head_blk = link_mem[head_blk[7:0]];
				if (used_blocks < POOL_BLOCKS) used_blocks = used_blocks + 9'd1;
			end
		end
		fbpa_pkg::CMD_FREE: begin
			if (w.free_addr < base_reg) begin
				r.status = fbpa_pkg::STAT_OUTSIDE;
			end else begin
				idx = (w.free_addr - base_reg) >> lg;
				if (idx >= 32'(total)) begin
					r.status = fbpa_pkg::STAT_OUTSIDE;
				end else begin
					link_mem[idx[7:0]] = head_blk;
					head_blk = idx[8:0];
					if (used_blocks > 0) used_blocks = used_blocks - 9'd1;
				end
			end
		end
		fbpa_pkg::CMD_REBUILD: begin
			for (int i = 0; i + 1 < total; i++) link_mem[i] = 9'(i + 1);
			link_mem[total - 1] = 9'(POOL_BLOCKS);
			head_blk = '0;
			used_blocks = '0;
		end
		default: ;
		endcase
		r.allocated_count = used_blocks;
		return r;
	endfunction

	function automatic fbpa_pkg::req_t make_word(input logic [1:0] c, input logic [16:0] b,
			input logic [31:0] a);
		fbpa_pkg::req_t w;
		w.cmd = c;
		w.request_bytes = b;
		w.free_addr = a;
		return w;
	endfunction

	// Predict, then queue the word and its reply; track granted blocks
	task automatic queue_word(input fbpa_pkg::req_t w);
		fbpa_pkg::rsp_t r;
		r = predict_reply(w);
		if (w.cmd == fbpa_pkg::CMD_ALLOC && r.status == fbpa_pkg::STAT_OK)
			owned_addr_q.push_back(r.granted_addr);
		if (w.cmd == fbpa_pkg::CMD_REBUILD) owned_addr_q.delete();
		words_to_send_q.push_back(w);
		replies_due_q.push_back(r);
	endtask

	// Mostly alloc/free of owned blocks; some oversize, stray frees, rebuilds, unused codes
	task automatic queue_random_word();
		fbpa_pkg::req_t w;
		int pick;
		int k;
		logic [31:0] blk_bytes;
		logic [31:0] span;
		blk_bytes = 32'd1 << shift_now();
		span = blk_bytes * total_now();
		w = make_word(fbpa_pkg::CMD_ALLOC, 17'($urandom), $urandom);
		pick = $urandom_range(0, 99);
		if (pick < 40 || (pick < 75 && owned_addr_q.size() == 0)) begin
			case ($urandom_range(0, 3))
			0: w.request_bytes = '0;
			1: w.request_bytes = blk_bytes[16:0];
			default: w.request_bytes = 17'($urandom_range(0, blk_bytes));
			endcase
		end else if (pick < 75) begin
			k = $urandom_range(0, owned_addr_q.size() - 1);
			w.cmd = fbpa_pkg::CMD_FREE;
			w.free_addr = owned_addr_q[k] + ($urandom() & (blk_bytes - 1));
			owned_addr_q.delete(k);
		end else if (pick < 84) begin
			if ($urandom_range(0, 1) == 0) w.request_bytes = 17'(blk_bytes + 1);
			else w.request_bytes = 17'($urandom_range(blk_bytes + 1, 131071));
		end else if (pick < 96) begin
			w.cmd = fbpa_pkg::CMD_FREE;
			case ($urandom_range(0, 3))
			0: w.free_addr = base_reg + $urandom_range(0, span - 1);
			1: w.free_addr = base_reg - $urandom_range(1, 4096);
			2: w.free_addr = base_reg + span + $urandom_range(0, 4095);
			default: w.free_addr = $urandom;
			endcase
		end else if (pick < 98) begin
			w.cmd = fbpa_pkg::CMD_REBUILD;
		end else begin
			w.cmd = CMD_UNUSED;
		end
		queue_word(w);
	endtask

	task automatic cfg_write(input logic [fbpa_pkg::CFG_INDEX_W-1:0] idx,
			input logic [31:0] value);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		case (idx)
		fbpa_pkg::REG_POOL_BASE: base_reg = value;
		fbpa_pkg::REG_BLOCK_TOTAL: total_reg = value[8:0];
		fbpa_pkg::REG_BLOCK_LOG2: shift_reg = value[4:0];
		default: ;
		endcase
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic set_pool(input logic [31:0] base, input logic [8:0] total,
			input logic [4:0] lg);
		cfg_write(fbpa_pkg::REG_POOL_BASE, base);
		cfg_write(fbpa_pkg::REG_BLOCK_TOTAL, 32'(total));
		cfg_write(fbpa_pkg::REG_BLOCK_LOG2, 32'(lg));
		owned_addr_q.delete();
	endtask

	// Wait for every word and reply, then let a rebuild sweep finish
	task automatic drain();
		while (words_to_send_q.size() != 0 || replies_due_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Stimulus
	initial begin
		int p;
		reset_pool();
		repeat (10) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Reset settings: 256 blocks of 32 bytes at address zero
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'd0, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'd32, 32'hFFFF_FFFF));
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'd33, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'd65536, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'h1FFFF, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'h1FFFF, 32'd63));
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'd0, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'd0, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'd0, 32'd8192));
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'd0, 32'hFFFF_FFFF));
		queue_word(make_word(CMD_UNUSED, 17'h1FFFF, 32'hFFFF_FFFF));
		queue_word(make_word(fbpa_pkg::CMD_REBUILD, 17'd0, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'd16, 32'd0));
		drain();

		// Two-block pool of 8 bytes; the list is stale until the rebuild
		set_pool(32'h0000_1000, 9'd2, 5'd3);
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'd0, 32'h0000_0FFF));
		queue_word(make_word(fbpa_pkg::CMD_REBUILD, 17'd0, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'd8, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'd1, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'd0, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'd9, 32'd0));
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'd0, 32'h0000_100F));
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'd0, 32'h0000_1010));
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'd0, 32'h0000_1000));
		queue_word(make_word(fbpa_pkg::CMD_FREE, 17'd0, 32'h0000_1000));
		// Double free left block 0 linked to itself: run the count into its ceiling
		repeat (SATURATE_ALLOCS)
			queue_word(make_word(fbpa_pkg::CMD_ALLOC, 17'($urandom_range(0, 8)), $urandom));
		drain();

		for (p = 0; p < 8; p++) begin
			case (p)
			0: set_pool($urandom, 9'd256, 5'd3);
			1: set_pool(32'hFFFF_F000, 9'd256, 5'd16);
			2: set_pool($urandom, 9'd1, 5'($urandom_range(3, 16)));
			3: set_pool($urandom, 9'd0, 5'd2);
			4: set_pool($urandom, 9'd400, 5'd31);
			5: set_pool(32'hFFFF_FFFF, 9'd3, 5'd4);
			default: set_pool($urandom, 9'($urandom_range(1, 256)), 5'($urandom_range(3, 16)));
			endcase
			if (p == 1 || $urandom_range(0, 3) != 0)
				queue_word(make_word(fbpa_pkg::CMD_REBUILD, 17'($urandom), $urandom));
			repeat (WORDS_PER_PHASE) queue_random_word();
			drain();
		end

		if (error_count == 0 && replies_due_q.size() == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

	// Driver: offer queued words in bursts, hold a stalled word steady
	int burst_left = 0;
	int gap_left = 0;
	logic valid_next;
	fbpa_pkg::req_t word_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			req_valid <= 1'b0;
			req <= '0;
		end else begin
			if (req_valid && !req_stall) begin
				void'(words_to_send_q.pop_front());
				words_taken <= words_taken + 1;
			end
			word_next = req;
			valid_next = 1'b0;
			if (req_valid && req_stall) begin
				valid_next = 1'b1;
			end else if (gap_left > 0) begin
				gap_left--;
			end else if (words_to_send_q.size() != 0) begin
				valid_next = 1'b1;
				word_next = words_to_send_q[0];
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, ($urandom_range(0, 4) == 0) ? 80 : 16);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end
			req_valid <= valid_next;
			req <= word_next;
		end
	end

	// Reply stall: changing patterns, plus one long hold-off under load
	int stall_mode = 0;
	int mode_left = 0;
	int hold_left = 0;
	int stall_tick = 0;
	bit hold_done = 1'b0;
	logic stall_next;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_stall <= 1'b0;
		end else begin
			stall_tick++;
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 3);
				mode_left = $urandom_range(32, 400);
			end else begin
				mode_left--;
			end
			if (hold_left > 0) begin
				hold_left--;
				stall_next = 1'b1;
			end else if (!hold_done && words_taken >= 500 && words_to_send_q.size() >= 40) begin
				hold_done = 1'b1;
				hold_left = HOLD_CYCLES - 1;
				stall_next = 1'b1;
			end else begin
				case (stall_mode)
				0: stall_next = 1'b0;
				1: stall_next = ($urandom_range(0, 3) == 0);
				2: stall_next = ($urandom_range(0, 3) != 0);
				default: stall_next = ((stall_tick % 7) < 3);
				endcase
			end
			rsp_stall <= stall_next;
		end
	end

	task automatic check_field(input string what, input logic [31:0] want,
			input logic [31:0] got);
		if (want !== got) begin
			error_count++;
			$display("%0t: %s mismatch: expected %h actual %h", $time, what, want, got);
		end
	endtask

	// Monitor: match each accepted reply against the oldest prediction
	fbpa_pkg::rsp_t reply_want;

	always @(posedge clk) begin
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (replies_due_q.size() == 0) begin
				error_count++;
				$display("%0t: reply with none due: expected none actual %h", $time, rsp);
			end else begin
				reply_want = replies_due_q.pop_front();
				check_field("status", 32'(reply_want.status), 32'(rsp.status));
				check_field("granted_addr", reply_want.granted_addr, rsp.granted_addr);
				check_field("allocated_count", 32'(reply_want.allocated_count),
					32'(rsp.allocated_count));
			end
		end
	end

	// Watchdog: count cycles with work outstanding and no word moving
	always @(posedge clk) begin
		if (!arst_n || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)
				|| (words_to_send_q.size() == 0 && replies_due_q.size() == 0)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no word moved for %0d cycles", $time, IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

endmodule

// File: sim.f
hw/rtl/fbpa_pkg.sv
hw/rtl/fbpa_ram.sv
hw/rtl/fbpa_addr_map.sv
hw/rtl/fixed_block_pool_allocator.sv
sim/fixed_block_pool_allocator_test.sv
